// ===== hw/rtl/cur_pkg.sv =====
// shared types, codes and constants for the chunked update receiver
// no dependencies; imported by every module of the block
`default_nettype none

package cur_pkg;

  // largest chunk the receiver takes, in bytes
  localparam int unsigned MAX_CHUNK = 256;
  localparam int unsigned CHUNK_W   = $clog2(MAX_CHUNK + 1);

  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  typedef enum logic [2:0] {
    KIND_NONE         = 3'd0,
    KIND_START        = 3'd1,
    KIND_DATA_START   = 3'd2,
    KIND_CHUNK_HEADER = 3'd3,
    KIND_CHUNK_BYTE   = 3'd4,
    KIND_END          = 3'd5,
    KIND_ABORT        = 3'd6,
    KIND_UNKNOWN      = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_PREP = 2'd1,
    PHASE_MBOX = 2'd2,
    PHASE_DONE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    STATUS_IDLE  = 3'd0,
    STATUS_READY = 3'd1,
    STATUS_BUSY  = 3'd2,
    STATUS_ERROR = 3'd3,
    STATUS_DONE  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    CAUSE_NONE          = 4'd0,
    CAUSE_ZERO_SIZE     = 4'd1,
    CAUSE_BEGIN_FAIL    = 4'd2,
    CAUSE_WRONG_STATE   = 4'd3,
    CAUSE_MAILBOX_FAIL  = 4'd4,
    CAUSE_BAD_CHUNK     = 4'd5,
    CAUSE_NO_MESSAGE    = 4'd6,
    CAUSE_LEN_MISMATCH  = 4'd7,
    CAUSE_CRC_MISMATCH  = 4'd8,
    CAUSE_WRITE_FAIL    = 4'd9,
    CAUSE_TOTAL_MISMATCH = 4'd10,
    CAUSE_END_FAIL      = 4'd11
  } cause_t;

  // one command word as held in the input register
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] total_size;
    logic        begin_ok;
    logic        mailbox_ok;
    logic [31:0] chunk_size;
    logic [31:0] expected_crc;
    logic        message_present;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        flash_ok;
  } item_t;

  // one result word
  typedef struct packed {
    logic        written;
    status_t     status;
    logic        in_progress;
    cause_t      cause;
    logic [31:0] bytes_received;
    logic [31:0] chunks_accepted;
  } result_t;

  // receiver state
  typedef struct packed {
    phase_t              phase;
    logic [31:0]         total_size_held;
    logic [31:0]         received_count;
    logic [31:0]         chunk_count;
    logic [31:0]         running_crc;
    logic [CHUNK_W-1:0]  chunk_length_held;
    logic [31:0]         crc_target;
    logic [CHUNK_W-1:0]  byte_counter;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:             PHASE_IDLE,
    total_size_held:   32'd0,
    received_count:    32'd0,
    chunk_count:       32'd0,
    running_crc:       CRC_ONES,
    chunk_length_held: '0,
    crc_target:        32'd0,
    byte_counter:      '0
  };

endpackage

`default_nettype wire

// ===== hw/rtl/cur_crc_byte.sv =====
// byte-wide reflected crc-32 update, eight bit steps unrolled
// uses cur_pkg for the polynomial
`default_nettype none

module cur_crc_byte
  import cur_pkg::*;
(
  input  wire logic [31:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [31:0] crc_out
);

  // shift out eight bits, folding in the polynomial on a set lsb
  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cur_core.sv =====
// command decode, checks and state registers of the update receiver
// uses cur_pkg and cur_crc_byte
`default_nettype none

module cur_core
  import cur_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire item_t   item,
  input  wire logic    fire,
  output result_t      res
);

  state_t      st;
  state_t      st_next;
  logic [31:0] crc_new;
  logic [CHUNK_W-1:0] cnt_inc;
  logic        written;
  status_t     stat;
  cause_t      cause;

  cur_crc_byte u_crc (
    .crc_in  (st.running_crc),
    .data_in (item.data_byte),
    .crc_out (crc_new)
  );

  assign cnt_inc = st.byte_counter + CHUNK_W'(1);

  // next state and result for the word in the input register
  always_comb begin
    st_next = st;
    written = 1'b0;
    stat    = STATUS_IDLE;
    cause   = CAUSE_NONE;
    case (kind_t'(item.kind))
      KIND_START: begin
        written = 1'b1;
        if (item.total_size == 32'd0) begin
          cause = CAUSE_ZERO_SIZE;
        end else if (!item.begin_ok) begin
          cause = CAUSE_BEGIN_FAIL;
        end else begin
          st_next.phase             = PHASE_PREP;
          st_next.total_size_held   = item.total_size;
          st_next.received_count    = 32'd0;
          st_next.chunk_count       = 32'd0;
          st_next.chunk_length_held = '0;
          st_next.byte_counter      = '0;
          st_next.running_crc       = CRC_ONES;
          stat = STATUS_READY;
        end
      end
      KIND_DATA_START: begin
        written = 1'b1;
        if (st.phase != PHASE_PREP) begin
          cause = CAUSE_WRONG_STATE;
        end else if (!item.mailbox_ok) begin
          cause = CAUSE_MAILBOX_FAIL;
        end else begin
          st_next.phase = PHASE_MBOX;
          stat = STATUS_READY;
        end
      end
      KIND_CHUNK_HEADER: begin
        if (st.phase != PHASE_MBOX) begin
          cause = CAUSE_WRONG_STATE;
        end else begin
          written = 1'b1;
          if (item.chunk_size == 32'd0 || item.chunk_size > 32'(MAX_CHUNK)) begin
            cause = CAUSE_BAD_CHUNK;
          end else if (!item.mailbox_ok) begin
            cause = CAUSE_MAILBOX_FAIL;
          end else if (!item.message_present) begin
            cause = CAUSE_NO_MESSAGE;
          end else begin
            st_next.chunk_length_held = CHUNK_W'(item.chunk_size);
            st_next.crc_target        = item.expected_crc;
            st_next.byte_counter      = '0;
            st_next.running_crc       = CRC_ONES;
            stat = STATUS_BUSY;
          end
        end
      end
      KIND_CHUNK_BYTE: begin
        if (st.phase != PHASE_MBOX || st.chunk_length_held == '0) begin
          cause = CAUSE_WRONG_STATE;
        end else begin
          st_next.byte_counter = cnt_inc;
          st_next.running_crc  = crc_new;
          if (cnt_inc > st.chunk_length_held) begin
            written = 1'b1;
            cause   = CAUSE_LEN_MISMATCH;
          end else if (item.last_byte) begin
            written = 1'b1;
            if (cnt_inc != st.chunk_length_held) begin
              cause = CAUSE_LEN_MISMATCH;
            end else if ((crc_new ^ CRC_ONES) != st.crc_target) begin
              cause = CAUSE_CRC_MISMATCH;
            end else if (!item.flash_ok) begin
              cause = CAUSE_WRITE_FAIL;
            end else begin
              st_next.received_count = st.received_count
                + {{(32 - CHUNK_W){1'b0}}, st.chunk_length_held};
              st_next.chunk_count       = st.chunk_count + 32'd1;
              st_next.chunk_length_held = '0;
              st_next.byte_counter      = '0;
              st_next.running_crc       = CRC_ONES;
              stat = STATUS_READY;
            end
          end
        end
      end
      KIND_END: begin
        if (st.phase != PHASE_MBOX && st.phase != PHASE_PREP) begin
          cause = CAUSE_WRONG_STATE;
        end else begin
          written = 1'b1;
          st_next.chunk_length_held = '0;
          st_next.byte_counter      = '0;
          st_next.running_crc       = CRC_ONES;
          if (st.received_count != st.total_size_held) begin
            cause = CAUSE_TOTAL_MISMATCH;
          end else if (!item.flash_ok) begin
            cause = CAUSE_END_FAIL;
          end else begin
            st_next.phase = PHASE_DONE;
            stat = STATUS_DONE;
          end
        end
      end
      KIND_ABORT: begin
        st_next = STATE_RESET;
        written = 1'b1;
        stat    = STATUS_IDLE;
      end
      default: begin
      end
    endcase

    // any reported failure drops the whole session
    if (written && cause != CAUSE_NONE) begin
      st_next = STATE_RESET;
      stat    = STATUS_ERROR;
    end
  end

  // state registers, updated as each word moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // result word
  always_comb begin
    res.written         = written;
    res.status          = written ? stat : STATUS_IDLE;
    res.in_progress     = (st_next.phase != PHASE_IDLE);
    res.cause           = cause;
    res.bytes_received  = st_next.received_count;
    res.chunks_accepted = st_next.chunk_count;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chunked_update_receiver_crc32_top.sv =====
// path: input register, then the core's crc and checks, then the result register
// throughput: one word per cycle unless stalled; crc and checks sit in one stage
// stalls: ready drops only when both registers are full and out_ready is low
// reset: synchronous rst empties both registers, sets phase idle, counts to
// zero and the running crc to all ones
// top level of the update receiver; uses cur_pkg and cur_core
`default_nettype none

module chunked_update_receiver_crc32_top
  import cur_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  kind,
  input  wire logic [31:0] total_size,
  input  wire logic        begin_ok,
  input  wire logic        mailbox_ok,
  input  wire logic [31:0] chunk_size,
  input  wire logic [31:0] expected_crc,
  input  wire logic        message_present,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        flash_ok,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             status_written,
  output logic [2:0]       status,
  output logic             in_progress,
  output logic [3:0]       error_cause,
  output logic [31:0]      bytes_received,
  output logic [31:0]      chunks_accepted
);

  item_t   item;
  logic    item_valid;
  logic    out_free;
  logic    fire;
  result_t res;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !item_valid || out_free;
  assign fire     = item_valid && out_free;

  // valid bits of the input and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= item_valid;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{
        kind:            kind,
        total_size:      total_size,
        begin_ok:        begin_ok,
        mailbox_ok:      mailbox_ok,
        chunk_size:      chunk_size,
        expected_crc:    expected_crc,
        message_present: message_present,
        data_byte:       data_byte,
        last_byte:       last_byte,
        flash_ok:        flash_ok
      };
    end
  end

  cur_core u_core (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .fire (fire),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      status_written  <= res.written;
      status          <= res.status;
      in_progress     <= res.in_progress;
      error_cause     <= res.cause;
      bytes_received  <= res.bytes_received;
      chunks_accepted <= res.chunks_accepted;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cur_checker.sv =====
// port-level checks on the update receiver result stream
// uses cur_pkg; bound to chunked_update_receiver_crc32_top
`default_nettype none

module cur_checker
  import cur_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        status_written,
  input wire logic [2:0]  status,
  input wire logic        in_progress,
  input wire logic [3:0]  error_cause,
  input wire logic [31:0] bytes_received,
  input wire logic [31:0] chunks_accepted
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(error_cause)
      && $stable(bytes_received))
    else $error("result word changed while stalled");

  // no status without a status update
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status_written |-> status == STATUS_IDLE
      && (error_cause == CAUSE_NONE || error_cause == CAUSE_WRONG_STATE))
    else $error("unwritten status carries a value");

  // an error ends the session and clears the counts
  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_written && status == STATUS_ERROR |-> !in_progress
      && bytes_received == 32'd0 && chunks_accepted == 32'd0
      && error_cause != CAUSE_NONE)
    else $error("error result without cleared session");

  // done, ready and busy leave a session open with no cause
  a_done_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_written && (status == STATUS_DONE || status == STATUS_READY
      || status == STATUS_BUSY) |-> in_progress && error_cause == CAUSE_NONE)
    else $error("success status without session");

endmodule

bind chunked_update_receiver_crc32_top cur_checker u_cur_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .status_written  (status_written),
  .status          (status),
  .in_progress     (in_progress),
  .error_cause     (error_cause),
  .bytes_received  (bytes_received),
  .chunks_accepted (chunks_accepted)
);

`default_nettype wire
